// ===== rtl/sd_command_sequencer_core_assert.svh =====
// Assertion macros shared by the SD command sequencer RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef SD_COMMAND_SEQUENCER_CORE_ASSERT_SVH
`define SD_COMMAND_SEQUENCER_CORE_ASSERT_SVH

// Check that is masked while reset is asserted.
`define SDCS_CHECK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that also holds during reset.
`define SDCS_CHECK_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/sdcs_pkg.sv =====
// Types and constants for the SD command sequencer.
// No dependencies; imported by sd_command_sequencer_core.
`timescale 1ns / 1ps

package sdcs_pkg;

	localparam int unsigned TICKS_W   = 24;
	localparam int unsigned IN_DATA_W  = 216;
	localparam int unsigned OUT_DATA_W = 176;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_DMA    = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		RC_OK          = 4'd0,
		RC_CMDCRC      = 4'd1,
		RC_CMDTIMEOUT  = 4'd2,
		RC_MISMATCH    = 4'd3,
		RC_CARDSTATUS  = 4'd4,
		RC_RXOVERRUN   = 4'd5,
		RC_DATACRC     = 4'd6,
		RC_DATATIMEOUT = 4'd7,
		RC_STARTBIT    = 4'd8,
		RC_UNKNOWN     = 4'd9,
		RC_DMA         = 4'd10,
		RC_SYSTIMEOUT  = 4'd11
	} result_code_t;

	// response_type codes
	localparam logic [2:0] RT_SHORT = 3'd1;
	localparam logic [2:0] RT_R3    = 3'd2;
	localparam logic [2:0] RT_R1    = 3'd3;
	localparam logic [2:0] RT_LONG  = 3'd4;

	// data_type / data direction codes
	localparam logic [1:0] DT_NONE  = 2'd0;
	localparam logic [1:0] DT_READ  = 2'd1;
	localparam logic [1:0] DT_WRITE = 2'd2;

	// issue_response_kind codes
	localparam logic [1:0] RK_NONE  = 2'd0;
	localparam logic [1:0] RK_SHORT = 2'd1;
	localparam logic [1:0] RK_LONG  = 2'd2;

	// status_flags bit positions
	localparam int unsigned FL_CCRCFAIL  = 0;
	localparam int unsigned FL_CTIMEOUT  = 1;
	localparam int unsigned FL_CMDREND   = 2;
	localparam int unsigned FL_RXOVERR   = 4;
	localparam int unsigned FL_DCRCFAIL  = 5;
	localparam int unsigned FL_DTIMEOUT  = 6;
	localparam int unsigned FL_STBITERR  = 7;
	localparam int unsigned FL_DMA_ERR   = 8;
	localparam int unsigned FL_DMA_DONE  = 9;

	// configuration register indexes
	localparam logic [1:0] REG_CMD_TO   = 2'd0;
	localparam logic [1:0] REG_READ_TO  = 2'd1;
	localparam logic [1:0] REG_WRITE_TO = 2'd2;

	localparam logic [TICKS_W-1:0] CMD_TO_RST   = 24'd10000;
	localparam logic [TICKS_W-1:0] READ_TO_RST  = 24'd1000000;
	localparam logic [TICKS_W-1:0] WRITE_TO_RST = 24'd1000;

	localparam logic [31:0] CS_ERROR_MASK = 32'hFD7F_E008;
	localparam logic [5:0]  APP_CMD_INDEX = 6'd55;

endpackage

// ===== rtl/sd_command_sequencer_core.sv =====
// SD card host command sequencer, top level.
// Depends on sdcs_pkg and sd_command_sequencer_core_assert.svh.
`timescale 1ns / 1ps
`include "sd_command_sequencer_core_assert.svh"

// Sequences one SD command at a time. A start beat latches the command; if it
// is an application command, CMD55 with the card address goes out first and
// its R1 response is checked. The command is then issued, its response checked
// by type, and an optional read or write data phase closes on data-path or DMA
// flags. Timeouts count tick beats. Response, timeout and DMA errors reissue
// the whole sequence while retries remain, else it completes with an error
// code; data-path flags complete it without retry. Status, DMA and tick beats
// arriving while idle, and starts while busy, are dropped. Throughput: one input
// beat per clock while no held result stalls the output. Each beat is evaluated
// in the input register against the sequencer state in a single pass, and its
// result (if any) lands in the output register. s_tready drops only while the
// input register is full and the output register holds a result not being taken.
module sd_command_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata, low bit up: cmd_index[5:0], app_cmd[6], argument[38:7],
	// card_address[54:39], response_type[57:55], data_type[59:58],
	// retries[67:60], status_flags[77:68], resp_cmd_index[83:78],
	// response_low[147:84], response_high[211:148], zero fill to 215
	input  logic [sdcs_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [1:0]                          s_tuser,   // kind
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata, low bit up: issue_index[5:0], issue_argument[37:6],
	// issue_response_kind[39:38], issue_data_dir[41:40], result_code[45:42],
	// resp_low[109:46], resp_high[173:110], zero fill to 175
	output logic [sdcs_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [1:0]                          m_tuser,   // issue_valid[0], done_res[1]
	// configuration writes
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [sdcs_pkg::TICKS_W-1:0]        cfg_wdata
);
	import sdcs_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_PREFIX = 3'd1,
		PH_CMD    = 3'd2,
		PH_READ   = 3'd3,
		PH_WRITE  = 3'd4
	} phase_t;

	// ---------------- configuration ----------------
	logic [TICKS_W-1:0] cmd_to_q, read_to_q, write_to_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_to_q   <= CMD_TO_RST;
			read_to_q  <= READ_TO_RST;
			write_to_q <= WRITE_TO_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CMD_TO:   cmd_to_q   <= cfg_wdata;
				REG_READ_TO:  read_to_q  <= cfg_wdata;
				REG_WRITE_TO: write_to_q <= cfg_wdata;
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                 valid_s1;
	kind_t                kind_s1;
	logic [IN_DATA_W-1:0] data_s1;
	logic                 adv;

	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= kind_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	// beat fields
	logic [5:0]  in_index;
	logic        in_app;
	logic [31:0] in_arg;
	logic [15:0] in_addr;
	logic [2:0]  in_rtype;
	logic [1:0]  in_dtype;
	logic [7:0]  in_retries;
	logic [9:0]  in_flags;
	logic [5:0]  in_echo;
	logic [63:0] in_resp_lo, in_resp_hi;

	assign in_index   = data_s1[5:0];
	assign in_app     = data_s1[6];
	assign in_arg     = data_s1[38:7];
	assign in_addr    = data_s1[54:39];
	assign in_rtype   = data_s1[57:55];
	assign in_dtype   = data_s1[59:58];
	assign in_retries = data_s1[67:60];
	assign in_flags   = data_s1[77:68];
	assign in_echo    = data_s1[83:78];
	assign in_resp_lo = data_s1[147:84];
	assign in_resp_hi = data_s1[211:148];

	// ---------------- sequencer state ----------------
	phase_t             phase_q, phase_n;
	logic [5:0]         idx_q, idx_n;
	logic               app_q, app_n;
	logic [31:0]        arg_q, arg_n;
	logic [15:0]        addr_q, addr_n;
	logic [2:0]         rtype_q, rtype_n;
	logic [1:0]         dtype_q, dtype_n;
	logic [7:0]         retries_q, retries_n;
	logic [TICKS_W-1:0] timer_q, timer_n;
	logic [63:0]        cap_lo_q, cap_lo_n, cap_hi_q, cap_hi_n;

	// evaluation of the beat in the input register
	logic         do_issue, issue_app, do_fail, do_finish;
	result_code_t fail_code, fin_code, code;
	logic         card_err;

	logic         res_valid, res_issue, res_done;
	logic [5:0]   res_index;
	logic [31:0]  res_arg;
	logic [1:0]   res_rkind, res_ddir;
	result_code_t res_code;

	// output stalls only when a held result is not taken
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign card_err = |(in_resp_lo[31:0] & CS_ERROR_MASK);

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		app_n     = app_q;
		arg_n     = arg_q;
		addr_n    = addr_q;
		rtype_n   = rtype_q;
		dtype_n   = dtype_q;
		retries_n = retries_q;
		timer_n   = timer_q;
		cap_lo_n  = cap_lo_q;
		cap_hi_n  = cap_hi_q;
		do_issue  = 1'b0;
		issue_app = app_q;
		do_fail   = 1'b0;
		fail_code = RC_OK;
		do_finish = 1'b0;
		fin_code  = RC_OK;
		code      = RC_OK;
		res_issue = 1'b0;
		res_done  = 1'b0;
		res_index = '0;
		res_arg   = '0;
		res_rkind = RK_NONE;
		res_ddir  = DT_NONE;
		res_code  = RC_OK;

		if (adv) begin
			case (kind_s1)
				KIND_START: begin
					if (phase_q == PH_IDLE) begin
						idx_n     = in_index;
						app_n     = in_app;
						arg_n     = in_arg;
						addr_n    = in_addr;
						rtype_n   = in_rtype;
						dtype_n   = in_dtype;
						retries_n = in_retries;
						cap_lo_n  = '0;
						cap_hi_n  = '0;
						do_issue  = 1'b1;
						issue_app = in_app;
					end
				end
				KIND_TICK: begin
					if (phase_q != PH_IDLE) begin
						if (timer_q > 24'd1) begin
							timer_n = timer_q - 24'd1;
						end else begin
							timer_n   = '0;
							do_fail   = 1'b1;
							fail_code = RC_SYSTIMEOUT;
						end
					end
				end
				KIND_DMA: begin
					// acts only while a transfer is armed; error wins
					if (phase_q != PH_IDLE && phase_q != PH_PREFIX &&
					    (dtype_q == DT_READ || dtype_q == DT_WRITE)) begin
						if (in_flags[FL_DMA_ERR]) begin
							do_fail   = 1'b1;
							fail_code = RC_DMA;
						end else if (in_flags[FL_DMA_DONE]) begin
							do_finish = 1'b1;
							fin_code  = RC_OK;
						end
					end
				end
				KIND_STATUS: begin
					case (phase_q)
						PH_PREFIX: begin
							if (in_flags[FL_CCRCFAIL]) code = RC_CMDCRC;
							if (in_flags[FL_CTIMEOUT]) code = RC_CMDTIMEOUT;
							if (in_flags[FL_CMDREND]) begin
								if (in_echo != APP_CMD_INDEX) code = RC_MISMATCH;
								cap_lo_n[31:0] = in_resp_lo[31:0];
								if (card_err) code = RC_CARDSTATUS;
							end
							if (code != RC_OK) begin
								do_fail   = 1'b1;
								fail_code = code;
							end else begin
								// prefix accepted: send the command proper
								do_issue  = 1'b1;
								issue_app = 1'b0;
							end
						end
						PH_CMD: begin
							case (rtype_q)
								RT_SHORT: begin
									if (in_flags[FL_CCRCFAIL]) code = RC_CMDCRC;
									if (in_flags[FL_CTIMEOUT]) code = RC_CMDTIMEOUT;
									if (in_flags[FL_CMDREND]) cap_lo_n[31:0] = in_resp_lo[31:0];
								end
								RT_R3: begin
									// CRC is not valid on R3: a crc flag still means a response
									if (in_flags[FL_CTIMEOUT]) code = RC_CMDTIMEOUT;
									if (in_flags[FL_CMDREND] || in_flags[FL_CCRCFAIL])
										cap_lo_n[31:0] = in_resp_lo[31:0];
								end
								RT_R1: begin
									if (in_flags[FL_CCRCFAIL]) code = RC_CMDCRC;
									if (in_flags[FL_CTIMEOUT]) code = RC_CMDTIMEOUT;
									if (in_flags[FL_CMDREND]) begin
										if (in_echo != idx_q) code = RC_MISMATCH;
										cap_lo_n[31:0] = in_resp_lo[31:0];
										if (card_err) code = RC_CARDSTATUS;
									end
								end
								RT_LONG: begin
									if (in_flags[FL_CCRCFAIL]) code = RC_CMDCRC;
									if (in_flags[FL_CTIMEOUT]) code = RC_CMDTIMEOUT;
									if (in_flags[FL_CMDREND]) begin
										cap_lo_n = in_resp_lo;
										cap_hi_n = in_resp_hi;
									end
								end
								default: ;   // no response expected
							endcase
							if (code != RC_OK) begin
								do_fail   = 1'b1;
								fail_code = code;
							end else if (dtype_q == DT_READ) begin
								phase_n = PH_READ;
								timer_n = read_to_q;
							end else if (dtype_q == DT_WRITE) begin
								phase_n = PH_WRITE;
								timer_n = write_to_q;
							end else begin
								do_finish = 1'b1;
								fin_code  = RC_OK;
							end
						end
						PH_READ, PH_WRITE: begin
							// data-path flags close the sequence, no retry
							code = RC_UNKNOWN;
							if (in_flags[FL_RXOVERR]) code = RC_RXOVERRUN;
							if (in_flags[FL_DCRCFAIL]) code = RC_DATACRC;
							if (in_flags[FL_DTIMEOUT]) code = RC_DATATIMEOUT;
							if (in_flags[FL_STBITERR]) code = RC_STARTBIT;
							do_finish = 1'b1;
							fin_code  = code;
						end
						default: ;   // idle
					endcase
				end
				default: ;
			endcase
		end

		// retry or give up
		if (do_fail) begin
			if (retries_q != 8'd0) begin
				retries_n = retries_q - 8'd1;
				do_issue  = 1'b1;
				issue_app = app_q;
			end else begin
				do_finish = 1'b1;
				fin_code  = fail_code;
			end
		end

		if (do_issue) begin
			timer_n   = cmd_to_q;
			res_issue = 1'b1;
			if (issue_app) begin
				phase_n   = PH_PREFIX;
				res_index = APP_CMD_INDEX;
				res_arg   = {addr_n, 16'h0000};
				res_rkind = RK_SHORT;
				res_ddir  = DT_NONE;
			end else begin
				phase_n   = PH_CMD;
				res_index = idx_n;
				res_arg   = arg_n;
				if (rtype_n == RT_LONG)
					res_rkind = RK_LONG;
				else if (rtype_n == RT_SHORT || rtype_n == RT_R3 || rtype_n == RT_R1)
					res_rkind = RK_SHORT;
				else
					res_rkind = RK_NONE;
				res_ddir = (dtype_n == DT_READ || dtype_n == DT_WRITE) ? dtype_n : DT_NONE;
			end
		end

		if (do_finish) begin
			phase_n  = PH_IDLE;
			timer_n  = '0;
			res_done = 1'b1;
			res_code = fin_code;
		end

		res_valid = res_issue || res_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			idx_q     <= '0;
			app_q     <= 1'b0;
			arg_q     <= '0;
			addr_q    <= '0;
			rtype_q   <= '0;
			dtype_q   <= '0;
			retries_q <= '0;
			timer_q   <= '0;
			cap_lo_q  <= '0;
			cap_hi_q  <= '0;
		end else begin
			phase_q   <= phase_n;
			idx_q     <= idx_n;
			app_q     <= app_n;
			arg_q     <= arg_n;
			addr_q    <= addr_n;
			rtype_q   <= rtype_n;
			dtype_q   <= dtype_n;
			retries_q <= retries_n;
			timer_q   <= timer_n;
			cap_lo_q  <= cap_lo_n;
			cap_hi_q  <= cap_hi_n;
		end
	end

	// ---------------- output register ----------------
	logic                  m_valid_q;
	logic [1:0]            m_user_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= res_valid;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			m_user_q <= {res_done, res_issue};
			m_data_q <= {2'b00, cap_hi_n, cap_lo_n, res_code, res_ddir, res_rkind,
			             res_arg, res_index};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_user_q;
	assign m_tdata  = m_data_q;

	// ---------------- checks ----------------
	`SDCS_CHECK_ALWAYS(a_idle_timer_clear, clk, (phase_q == PH_IDLE) |-> (timer_q == '0), "timer running while idle")
	`SDCS_CHECK(a_done_goes_idle, clk, arst_n, (adv && res_done) |=> (phase_q == PH_IDLE), "completion left sequencer busy")
	`SDCS_CHECK(a_issue_goes_busy, clk, arst_n, (adv && res_issue) |=> (phase_q == PH_PREFIX || phase_q == PH_CMD), "issue without command phase")
	`SDCS_CHECK(a_single_kind, clk, arst_n, (adv && res_valid) |=> (m_tvalid && (m_tuser[0] != m_tuser[1])), "result both issue and done")

endmodule

// ===== dv/tb_sd_command_sequencer_core.sv =====
// Self-checking testbench for sd_command_sequencer_core: random and directed command traffic,
// with an in-bench sequencer predictor checked beat by beat against the result stream.
// Depends on sdcs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_sd_command_sequencer_core;
	import sdcs_pkg::*;

	localparam int DRAIN_CYCLES = 6;   // input reg + output reg, plus margin
	localparam int HOLD_CYCLES  = 400; // long receiver back-pressure stretch

	// One input beat, unpacked into its fields.
	typedef struct {
		kind_t        kind;
		logic [5:0]   cmd_index;
		logic         app;
		logic [31:0]  argument;
		logic [15:0]  rca;
		logic [2:0]   resp_type;
		logic [1:0]   data_type;
		logic [7:0]   retries;
		logic [9:0]   flags;
		logic [5:0]   echo;
		logic [63:0]  rsp_lo;
		logic [63:0]  rsp_hi;
	} sd_beat_t;

	// One result beat, unpacked.
	typedef struct {
		logic         issue_valid;
		logic [5:0]   issue_index;
		logic [31:0]  issue_argument;
		logic [1:0]   issue_rk;
		logic [1:0]   issue_dd;
		logic         done;
		logic [3:0]   code;
		logic [63:0]  cap_lo;
		logic [63:0]  cap_hi;
	} seq_result_t;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_PREFIX, SEQ_CMD, SEQ_READ, SEQ_WRITE
	} seq_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_index = '0;
	logic [TICKS_W-1:0]    cfg_wdata = '0;
	logic                  receiver_hold = 1'b0;

	sd_beat_t    host_beats[$];   // beats waiting to go out on the input side
	sd_beat_t    beat_on_bus;     // beat currently offered on s_*
	seq_result_t outputs_due[$];  // predicted result beats, oldest first
	int          send_idle_pct = 29;
	int          recv_idle_pct = 68;
	int          mismatch_count = 0;
	int          results_seen = 0;
	int          stim_count = 0;
	event        long_hold_ev;

	// Predictor state: timeout registers plus the sequencer's own state.
	logic [23:0] cmd_to = CMD_TO_RST;
	logic [23:0] rd_to = READ_TO_RST;
	logic [23:0] wr_to = WRITE_TO_RST;
	seq_phase_t  seq_ph = SEQ_IDLE;
	logic [5:0]  cmd_idx_r = '0;
	logic        app_r = 1'b0;
	logic [31:0] arg_r = '0;
	logic [15:0] rca_r = '0;
	logic [2:0]  rtype_r = '0;
	logic [1:0]  dtype_r = '0;
	logic [7:0]  retry_left = '0;
	logic [23:0] ticks_left = '0;
	logic [63:0] cap_lo = '0;
	logic [63:0] cap_hi = '0;

	sd_command_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// Send the next command of the sequence: CMD55 first when prefixing,
	// otherwise the latched command with its response kind and data direction.
	function automatic void issue_cmd(input logic use_prefix);
		seq_result_t r;
		r = '{default: '0};
		ticks_left = cmd_to;
		r.issue_valid = 1'b1;
		if (use_prefix) begin
			seq_ph = SEQ_PREFIX;
			r.issue_index = APP_CMD_INDEX;
			r.issue_argument = {rca_r, 16'h0000};
			r.issue_rk = RK_SHORT;
		end else begin
			seq_ph = SEQ_CMD;
			r.issue_index = cmd_idx_r;
			r.issue_argument = arg_r;
			if (rtype_r == RT_LONG)
				r.issue_rk = RK_LONG;
			else if (rtype_r == RT_SHORT || rtype_r == RT_R3 || rtype_r == RT_R1)
				r.issue_rk = RK_SHORT;
			else
				r.issue_rk = RK_NONE;  // none, and undefined types 5..7
			r.issue_dd = (dtype_r == DT_READ || dtype_r == DT_WRITE) ? dtype_r : DT_NONE;
		end
		r.cap_lo = cap_lo;
		r.cap_hi = cap_hi;
		outputs_due.push_back(r);
	endfunction

	function automatic void complete(input result_code_t code);
		seq_result_t r;
		r = '{default: '0};
		seq_ph = SEQ_IDLE;
		ticks_left = '0;
		r.done = 1'b1;
		r.code = code;
		r.cap_lo = cap_lo;
		r.cap_hi = cap_hi;
		outputs_due.push_back(r);
	endfunction

	// Errors restart the whole sequence, CMD55 included, while retries last.
	function automatic void retry_or_finish(input result_code_t code);
		if (retry_left != 0) begin
			retry_left--;
			issue_cmd(app_r);
		end else begin
			complete(code);
		end
	endfunction

	// R1 check, shared by the CMD55 response and R1-typed commands.
	function automatic result_code_t check_r1(input sd_beat_t b, input logic [5:0] want_echo);
		result_code_t c;
		c = RC_OK;
		if (b.flags[FL_CCRCFAIL])
			c = RC_CMDCRC;
		if (b.flags[FL_CTIMEOUT])
			c = RC_CMDTIMEOUT;
		if (b.flags[FL_CMDREND]) begin
			if (b.echo != want_echo)
				c = RC_MISMATCH;
			cap_lo[31:0] = b.rsp_lo[31:0];
			if ((b.rsp_lo[31:0] & CS_ERROR_MASK) != '0)
				c = RC_CARDSTATUS;
		end
		return c;
	endfunction

	// Apply one accepted beat; queues the result it causes, if any.
	function automatic void advance_sequencer(input sd_beat_t b);
		result_code_t code;
		code = RC_OK;
		if (b.kind == KIND_START) begin
			// starts while busy are dropped
			if (seq_ph == SEQ_IDLE) begin
				cmd_idx_r = b.cmd_index;
				app_r = b.app;
				arg_r = b.argument;
				rca_r = b.rca;
				rtype_r = b.resp_type;
				dtype_r = b.data_type;
				retry_left = b.retries;
				cap_lo = '0;
				cap_hi = '0;
				issue_cmd(app_r);
			end
		end else if (seq_ph != SEQ_IDLE) begin
			case (b.kind)
			KIND_TICK: begin
				if (ticks_left > 24'd1) begin
					ticks_left--;
				end else begin
					ticks_left = '0;
					retry_or_finish(RC_SYSTIMEOUT);
				end
			end
			KIND_DMA: begin
				// DMA only counts once a transfer is armed; error wins over done
				if (seq_ph != SEQ_PREFIX && (dtype_r == DT_READ || dtype_r == DT_WRITE)) begin
					if (b.flags[FL_DMA_ERR])
						retry_or_finish(RC_DMA);
					else if (b.flags[FL_DMA_DONE])
						complete(RC_OK);
				end
			end
			default: begin
				case (seq_ph)
				SEQ_PREFIX: begin
					code = check_r1(b, APP_CMD_INDEX);
					if (code != RC_OK)
						retry_or_finish(code);
					else
						issue_cmd(1'b0);
				end
				SEQ_CMD: begin
					case (rtype_r)
					RT_SHORT: begin
						if (b.flags[FL_CCRCFAIL])
							code = RC_CMDCRC;
						if (b.flags[FL_CTIMEOUT])
							code = RC_CMDTIMEOUT;
						if (b.flags[FL_CMDREND])
							cap_lo[31:0] = b.rsp_lo[31:0];
					end
					RT_R3: begin
						// no CRC on R3: a CRC flag still means a response came in
						if (b.flags[FL_CTIMEOUT])
							code = RC_CMDTIMEOUT;
						if (b.flags[FL_CMDREND] || b.flags[FL_CCRCFAIL])
							cap_lo[31:0] = b.rsp_lo[31:0];
					end
					RT_R1: begin
						code = check_r1(b, cmd_idx_r);
					end
					RT_LONG: begin
						if (b.flags[FL_CCRCFAIL])
							code = RC_CMDCRC;
						if (b.flags[FL_CTIMEOUT])
							code = RC_CMDTIMEOUT;
						if (b.flags[FL_CMDREND]) begin
							cap_lo = b.rsp_lo;
							cap_hi = b.rsp_hi;
						end
					end
					default: ;
					endcase
					if (code != RC_OK) begin
						retry_or_finish(code);
					end else if (dtype_r == DT_READ) begin
						seq_ph = SEQ_READ;
						ticks_left = rd_to;
					end else if (dtype_r == DT_WRITE) begin
						seq_ph = SEQ_WRITE;
						ticks_left = wr_to;
					end else begin
						complete(RC_OK);
					end
				end
				default: begin
					// data phase: any status ends it, no retry; later flags win
					code = RC_UNKNOWN;
					if (b.flags[FL_RXOVERR])
						code = RC_RXOVERRUN;
					if (b.flags[FL_DCRCFAIL])
						code = RC_DATACRC;
					if (b.flags[FL_DTIMEOUT])
						code = RC_DATATIMEOUT;
					if (b.flags[FL_STBITERR])
						code = RC_STARTBIT;
					complete(code);
				end
				endcase
			end
			endcase
		end
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic sd_beat_t random_beat(input kind_t k);
		sd_beat_t b;
		b.kind = k;
		b.cmd_index = 6'($urandom);
		b.app = 1'($urandom);
		b.argument = $urandom;
		b.rca = 16'($urandom);
		b.resp_type = 3'($urandom);
		b.data_type = 2'($urandom);
		b.retries = 8'($urandom);
		b.flags = 10'($urandom);
		b.echo = 6'($urandom);
		b.rsp_lo = {$urandom, $urandom};
		b.rsp_hi = {$urandom, $urandom};
		return b;
	endfunction

	function automatic void queue_beat(input sd_beat_t b);
		host_beats.push_back(b);
		stim_count++;
	endfunction

	function automatic sd_beat_t queue_start(input logic [5:0] idx, input logic app,
			input logic [31:0] arg, input logic [15:0] rca, input logic [2:0] rtype,
			input logic [1:0] dtype, input logic [7:0] retries);
		sd_beat_t b;
		b = random_beat(KIND_START);
		b.cmd_index = idx;
		b.app = app;
		b.argument = arg;
		b.rca = rca;
		b.resp_type = rtype;
		b.data_type = dtype;
		b.retries = retries;
		queue_beat(b);
		return b;
	endfunction

	function automatic void queue_event(input kind_t k, input logic [9:0] flags,
			input logic [5:0] echo, input logic [63:0] lo, input logic [63:0] hi);
		sd_beat_t b;
		b = random_beat(k);
		b.flags = flags;
		b.echo = echo;
		b.rsp_lo = lo;
		b.rsp_hi = hi;
		queue_beat(b);
	endfunction

	// Mostly a clean R1-style reply, now and then a CRC, timeout, wrong echo or bad status.
	function automatic void queue_cmd_reply(input logic [5:0] want_echo);
		sd_beat_t b;
		b = random_beat(KIND_STATUS);
		b.flags[FL_CCRCFAIL] = ($urandom_range(99) < 10);
		b.flags[FL_CTIMEOUT] = ($urandom_range(99) < 8);
		b.flags[FL_CMDREND] = ($urandom_range(99) < 85);
		if ($urandom_range(99) < 92)
			b.echo = want_echo;
		if ($urandom_range(99) < 88)
			b.rsp_lo[31:0] = b.rsp_lo[31:0] & ~CS_ERROR_MASK;
		queue_beat(b);
	endfunction

	// Now and then a run of ticks, mostly short, sometimes long enough to hit a timeout.
	function automatic void queue_ticks();
		int pick;
		int n;
		pick = $urandom_range(99);
		n = 0;
		if (pick < 25)
			n = $urandom_range(1, 6);
		else if (pick < 30)
			n = $urandom_range(7, 20);
		repeat (n) queue_beat(random_beat(KIND_TICK));
	endfunction

	// A well-formed command exchange with random content, plus some noise.
	function automatic void queue_command();
		sd_beat_t cmd;
		sd_beat_t b;
		int pick;
		logic [2:0] rtype;
		logic [1:0] dtype;
		logic [7:0] retries;
		rtype = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		dtype = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		pick = $urandom_range(99);
		if (pick < 60)
			retries = '0;
		else if (pick < 90)
			retries = 8'($urandom_range(1, 3));
		else
			retries = 8'($urandom);
		cmd = queue_start(6'($urandom), 1'($urandom), $urandom, 16'($urandom),
			rtype, dtype, retries);
		queue_ticks();
		if (cmd.app) begin
			queue_cmd_reply(APP_CMD_INDEX);
			queue_ticks();
		end
		queue_cmd_reply(cmd.cmd_index);
		queue_ticks();
		if (cmd.data_type == DT_READ || cmd.data_type == DT_WRITE) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				b = random_beat(KIND_STATUS);
				pick = $urandom_range(9);
				if (pick < 2)
					b.flags[7:4] = 4'b0000;
				else if (pick < 8)
					b.flags[7:4] = 4'(1 << $urandom_range(3));
				queue_beat(b);
			end else if (pick < 90) begin
				b = random_beat(KIND_DMA);
				pick = $urandom_range(99);
				b.flags[FL_DMA_ERR] = (pick >= 60 && pick < 90);
				b.flags[FL_DMA_DONE] = (pick < 60 || (pick >= 80 && pick < 90));
				queue_beat(b);
			end
		end
		if ($urandom_range(99) < 15)
			queue_beat(random_beat(kind_t'($urandom_range(3))));
	endfunction

	function automatic void run_phase(input int n);
		int target;
		target = stim_count + n;
		while (stim_count < target)
			queue_command();
	endfunction

	// Wait until every predicted result has come back and the pipe is empty,
	// then push zero-flag status beats until the sequencer is idle again.
	// Queue and handshake state is checked on the falling edge, after the
	// driver has settled.
	task automatic settle_block();
		sd_beat_t b;
		bit busy;
		do begin
			while (host_beats.size() != 0 || s_tvalid || outputs_due.size() != 0)
				@(negedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			busy = (seq_ph != SEQ_IDLE);
			if (busy) begin
				b = random_beat(KIND_STATUS);
				b.flags = '0;
				queue_beat(b);
			end
		end while (busy);
	endtask

	task automatic write_timeouts(input logic [23:0] cmd_ticks, input logic [23:0] rd_ticks,
			input logic [23:0] wr_ticks);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_CMD_TO;
		cfg_wdata <= cmd_ticks;
		@(posedge clk);
		cfg_index <= REG_READ_TO;
		cfg_wdata <= rd_ticks;
		@(posedge clk);
		cfg_index <= REG_WRITE_TO;
		cfg_wdata <= wr_ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
		cmd_to = cmd_ticks;
		rd_to = rd_ticks;
		wr_to = wr_ticks;
	endtask

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got)
			note_mismatch($sformatf("result %0d %s: expected %h, got %h",
				results_seen, name, want, got));
	endfunction

	// ---------------------------------------------------------------- driver

	// Offers queued beats; the predictor advances on each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				advance_sequencer(beat_on_bus);
			if (!s_tvalid || s_tready) begin
				if (host_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_on_bus = host_beats.pop_front();
					s_tdata <= {4'b0000, beat_on_bus.rsp_hi, beat_on_bus.rsp_lo,
						beat_on_bus.echo, beat_on_bus.flags, beat_on_bus.retries,
						beat_on_bus.data_type, beat_on_bus.resp_type, beat_on_bus.rca,
						beat_on_bus.argument, beat_on_bus.app, beat_on_bus.cmd_index};
					s_tuser <= beat_on_bus.kind;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		seq_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (outputs_due.size() == 0) begin
					note_mismatch($sformatf("result %0d arrived with nothing predicted",
						results_seen));
				end else begin
					want = outputs_due.pop_front();
					compare_field("issue_valid", want.issue_valid, m_tuser[0]);
					compare_field("done_res", want.done, m_tuser[1]);
					compare_field("issue_index", want.issue_index, m_tdata[5:0]);
					compare_field("issue_argument", want.issue_argument, m_tdata[37:6]);
					compare_field("issue_response_kind", want.issue_rk, m_tdata[39:38]);
					compare_field("issue_data_dir", want.issue_dd, m_tdata[41:40]);
					compare_field("result_code", want.code, m_tdata[45:42]);
					compare_field("resp_low", want.cap_lo, m_tdata[109:46]);
					compare_field("resp_high", want.cap_hi, m_tdata[173:110]);
				end
			end
			m_tready <= !receiver_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver stall so the core backs up and drops s_tready.
	always begin
		@(long_hold_ev);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset timeouts.
		// long response, all ones captured, then events in idle are dropped
		void'(queue_start(6'd63, 1'b0, 32'hFFFF_FFFF, 16'h0000, RT_LONG, DT_NONE, 8'd0));
		queue_event(KIND_STATUS, 10'(1 << FL_CMDREND), 6'd63, '1, '1);
		queue_event(KIND_STATUS, 10'h3FF, 6'd0, '1, '1);
		queue_event(KIND_DMA, 10'h3FF, 6'd0, '0, '0);
		queue_event(KIND_TICK, 10'h000, 6'd0, '0, '0);
		// app command: wrong echo on CMD55 retries, start while busy is dropped
		void'(queue_start(6'd0, 1'b1, 32'h0000_0000, 16'hFFFF, RT_R1, DT_READ, 8'd1));
		void'(queue_start(6'd12, 1'b0, 32'hA5A5_A5A5, 16'h1234, RT_SHORT, DT_NONE, 8'd0));
		queue_event(KIND_STATUS, 10'(1 << FL_CMDREND), 6'd54, '0, '0);
		queue_event(KIND_STATUS, 10'(1 << FL_CMDREND), APP_CMD_INDEX,
			64'hFFFF_FFFF_0280_1FF7, '1);
		queue_event(KIND_DMA, 10'h000, 6'd0, '0, '0);  // armed, neither flag: dropped
		queue_event(KIND_STATUS, 10'(1 << FL_CMDREND), 6'd0, '0, '0);
		queue_event(KIND_STATUS, 10'h0F0, 6'd0, '0, '0);  // all data errors at once
		// R3 takes a CRC flag as a response; DMA error beats DMA done
		void'(queue_start(6'd41, 1'b0, 32'h1234_5678, 16'h0000, RT_R3, DT_WRITE, 8'd0));
		queue_event(KIND_STATUS, 10'(1 << FL_CCRCFAIL), 6'd3, {$urandom, $urandom}, '1);
		queue_event(KIND_DMA, 10'((1 << FL_DMA_ERR) | (1 << FL_DMA_DONE)), 6'd0, '0, '0);
		// timeout then retry, DMA done during the command phase
		void'(queue_start(6'd7, 1'b0, 32'h0000_0000, 16'h0000, RT_SHORT, DT_WRITE, 8'd2));
		queue_event(KIND_STATUS, 10'((1 << FL_CTIMEOUT) | (1 << FL_CCRCFAIL)), 6'd7, '0, '0);
		queue_event(KIND_DMA, 10'(1 << FL_DMA_DONE), 6'd0, '0, '0);
		// card status error in the R1 word
		void'(queue_start(6'd17, 1'b0, 32'hDEAD_BEEF, 16'h0000, RT_R1, DT_NONE, 8'd0));
		queue_event(KIND_STATUS, 10'(1 << FL_CMDREND), 6'd17, {32'h0, CS_ERROR_MASK}, '0);
		// undefined response and data types act as none
		void'(queue_start(6'd5, 1'b0, 32'h0000_0001, 16'h0000, 3'd5, 2'd3, 8'd0));
		queue_event(KIND_STATUS, 10'h000, 6'd0, '0, '0);
		// empty status in the data phase ends with unknown
		void'(queue_start(6'd9, 1'b0, 32'h8000_0000, 16'h0000, 3'd0, DT_READ, 8'd0));
		queue_event(KIND_STATUS, 10'h000, 6'd0, '0, '0);
		queue_event(KIND_STATUS, 10'h000, 6'd0, '0, '0);
		settle_block();

		// Shortest timeouts: every tick fires.
		write_timeouts(24'd1, 24'd1, 24'd1);
		run_phase(330);
		settle_block();

		// Small timeouts, with a long receiver stall up front.
		write_timeouts(24'($urandom_range(2, 12)), 24'($urandom_range(2, 20)),
			24'($urandom_range(2, 20)));
		-> long_hold_ev;
		run_phase(330);
		settle_block();

		// Swap the idle rates; largest timeouts, ticks never expire.
		send_idle_pct = 68;
		recv_idle_pct = 29;
		write_timeouts(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
		run_phase(330);
		settle_block();

		// Mixed, with the sender pausing until everything is back.
		write_timeouts(24'($urandom_range(1, 8)), 24'($urandom_range(1, 6)), 24'hFF_FFFF);
		run_phase(170);
		settle_block();
		run_phase(170);
		settle_block();

		// No idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_timeouts(24'($urandom_range(1, 15)), 24'($urandom_range(1, 15)),
			24'($urandom_range(1, 15)));
		run_phase(400);
		settle_block();

		mismatch_count += outputs_due.size();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog, far above the slowest legal run.
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
